@@ hdl/can_rxq_pkg.sv @@
package can_rxq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 16;
   localparam logic [28:0] EXT_ID_MASK     = 29'h1FFF_FFFF;
   localparam logic [10:0] STD_ID_MASK     = 11'h7FF;
   localparam logic [3:0]  MAX_LENGTH      = 4'd8;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_OFF   = 2'd3
   } status_type;

   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // stored header, 51 bits
   typedef struct packed {
      logic [15:0] timestamp;
      logic [3:0]  length;
      logic        remote;
      logic        extended;
      logic [28:0] id;
   } header_type;

   function automatic header_type decode_header(logic [31:0] id_word,
                                                logic [31:0] length_time_word);
      header_type h;
      h.extended  = id_word[2];
      h.remote    = id_word[1];
      h.id        = id_word[2] ? (id_word[31:3] & EXT_ID_MASK)
                               : {18'd0, id_word[31:21] & STD_ID_MASK};
      h.length    = (length_time_word[3:0] > MAX_LENGTH) ? MAX_LENGTH
                                                         : length_time_word[3:0];
      h.timestamp = length_time_word[31:16];
      return h;
   endfunction

endpackage

@@ hdl/can_rx_frame_queue.sv @@
// can_rx_frame_queue: receive frame queue with decode on push
// result path: accepted request beat, middle stage (memory read), output register, result beat
// throughput: one request beat per cycle while results are taken; set by the single
//   memory port pair, one read or one write per item
// reset: synchronous, active high; clears pointers, fill count, overflow count and enable;
//   frame memories are not cleared, no clearing pass
module can_rx_frame_queue
   import can_rxq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_id_word,
   input  logic [31:0] req_length_time_word,
   input  logic [31:0] req_data_low_word,
   input  logic [31:0] req_data_high_word,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [28:0] rsp_frame_id,
   output logic        rsp_frame_extended,
   output logic        rsp_frame_remote,
   output logic [3:0]  rsp_frame_length,
   output logic [15:0] rsp_frame_timestamp,
   output logic [31:0] rsp_frame_data_low,
   output logic [31:0] rsp_frame_data_high,
   output logic [4:0]  rsp_fill_level,
   output logic [15:0] rsp_overflow_count,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

   // frame memories, one synchronous read port, one write port
   header_type  hdr_mem [QUEUE_DEPTH];
   logic [63:0] pay_mem [QUEUE_DEPTH];
   header_type  rd_hdr_ff;
   logic [63:0] rd_pay_ff;

   // queue state
   logic          enable_ff, enable_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   dropped_ff, dropped_in;

   // middle stage: decided status, waiting on memory read data
   logic          mid_valid_ff, mid_valid_in;
   status_type    mid_status_ff, mid_status_in;
   logic          mid_pop_ff, mid_pop_in;
   logic [4:0]    mid_fill_ff, mid_fill_in;
   logic [15:0]   mid_ovf_ff, mid_ovf_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [1:0]    out_status_ff;
   header_type    out_hdr_ff;
   logic [63:0]   out_pay_ff;
   logic [4:0]    out_fill_ff;
   logic [15:0]   out_ovf_ff;

   logic          out_busy;
   logic          mid_move;
   logic          accept;
   logic          do_push;
   logic          do_pop;
   logic [CW+4:0] count_ext;
   header_type    push_hdr;

   // config port: single register, decoded on paddr[2] == 0 only (offsets 0 to 3), always ready
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == 1'b0) ? {31'd0, enable_ff} : 32'd0;
   assign enable_in = (psel && penable && pwrite && (paddr[2] == 1'b0)) ? pwdata[0]
                                                                        : enable_ff;

   // handshake: the middle stage drains whenever the output register is free
   assign out_busy  = out_valid_ff && rsp_stall;
   assign mid_move  = mid_valid_ff && !out_busy;
   assign req_stall = mid_valid_ff && out_busy;
   assign accept    = req_valid && !req_stall;

   assign push_hdr  = decode_header(req_id_word, req_length_time_word);

   // decide the item at accept time; pointers move right away so a
   // following beat sees the updated queue
   always_comb begin
      do_push       = 1'b0;
      do_pop        = 1'b0;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      mid_status_in = ST_OK;
      if (accept) begin
         priority if (!enable_ff) begin
            mid_status_in = ST_OFF;
         end else if (req_type == REQ_PUSH) begin
            if (count_ff >= CNT_FULL) begin
               mid_status_in = ST_FULL;
               if (dropped_ff != COUNT_MAX) begin
                  dropped_in = dropped_ff + 16'd1;
               end
            end else begin
               do_push   = 1'b1;
               wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
               count_in  = count_ff + CW'(1);
            end
         end else begin
            if (count_ff == '0) begin
               mid_status_in = ST_EMPTY;
            end else begin
               do_pop    = 1'b1;
               rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
               count_in  = count_ff - CW'(1);
            end
         end
      end
   end

   // fill level is the count masked to five bits
   assign count_ext   = {5'd0, count_in};
   assign mid_fill_in = count_ext[4:0];
   assign mid_ovf_in  = dropped_in;
   assign mid_pop_in  = do_pop;

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (accept) begin
         mid_valid_in = 1'b1;
      end else if (mid_move) begin
         mid_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (mid_move) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // memories: write on push, read on pop; never both in one cycle
   always_ff @(posedge clock) begin
      if (do_push) begin
         hdr_mem[wr_ptr_ff] <= push_hdr;
         pay_mem[wr_ptr_ff] <= {req_data_high_word, req_data_low_word};
      end
      if (do_pop) begin
         rd_hdr_ff <= hdr_mem[rd_ptr_ff];
         rd_pay_ff <= pay_mem[rd_ptr_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         dropped_ff   <= '0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // middle stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mid_status_ff <= mid_status_in;
         mid_pop_ff    <= mid_pop_in;
         mid_fill_ff   <= mid_fill_in;
         mid_ovf_ff    <= mid_ovf_in;
      end
   end

   // output register; frame fields are zero unless a frame was popped
   always_ff @(posedge clock) begin
      if (mid_move) begin
         out_status_ff <= mid_status_ff;
         out_hdr_ff    <= mid_pop_ff ? rd_hdr_ff : '0;
         out_pay_ff    <= mid_pop_ff ? rd_pay_ff : 64'd0;
         out_fill_ff   <= mid_fill_ff;
         out_ovf_ff    <= mid_ovf_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_frame_id        = out_hdr_ff.id;
   assign rsp_frame_extended  = out_hdr_ff.extended;
   assign rsp_frame_remote    = out_hdr_ff.remote;
   assign rsp_frame_length    = out_hdr_ff.length;
   assign rsp_frame_timestamp = out_hdr_ff.timestamp;
   assign rsp_frame_data_low  = out_pay_ff[31:0];
   assign rsp_frame_data_high = out_pay_ff[63:32];
   assign rsp_fill_level      = out_fill_ff;
   assign rsp_overflow_count  = out_ovf_ff;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench
   import can_rxq_pkg::*;
();

   localparam int          DEPTH        = 16;
   localparam int          SHOW_LIMIT   = 10;
   localparam logic [2:0]  ADDR_ENABLE  = 3'd0;
   localparam logic [3:0]  LEN_CLAMP    = 4'd8;
   localparam logic [15:0] DROP_CEILING = 16'hFFFF;
   localparam int          SETTLE       = 4;

   // one result beat, field by field
   typedef struct {
      status_type  status;
      logic [28:0] id;
      logic        extended;
      logic        remote;
      logic [3:0]  length;
      logic [15:0] timestamp;
      logic [31:0] bytes_lo;
      logic [31:0] bytes_hi;
      logic [4:0]  fill;
      logic [15:0] dropped;
   } rx_result_type;

   // one frame as the queue holds it
   typedef struct {
      logic [28:0] id;
      logic        extended;
      logic        remote;
      logic [3:0]  length;
      logic [15:0] timestamp;
      logic [63:0] data;
   } held_frame_type;

   // clock, reset and all block inputs start at known values
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_type = REQ_PUSH;
   logic [31:0] req_id_word = '0;
   logic [31:0] req_length_time_word = '0;
   logic [31:0] req_data_low_word = '0;
   logic [31:0] req_data_high_word = '0;
   logic        rsp_stall = 1'b0;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;

   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [28:0] rsp_frame_id;
   logic        rsp_frame_extended;
   logic        rsp_frame_remote;
   logic [3:0]  rsp_frame_length;
   logic [15:0] rsp_frame_timestamp;
   logic [31:0] rsp_frame_data_low;
   logic [31:0] rsp_frame_data_high;
   logic [4:0]  rsp_fill_level;
   logic [15:0] rsp_overflow_count;
   logic [31:0] prdata;
   logic        pready;

   // idle percentages of both sides and the receiver hold-off length
   int          req_idle_pct = 20;
   int          rsp_idle_pct = 20;
   int          hold_left = 0;
   int          mismatches = 0;

   // shadow of the queue contents and counters
   held_frame_type shadow_frames [DEPTH];
   int          shadow_wr = 0;
   int          shadow_rd = 0;
   int          shadow_held = 0;
   logic [15:0] shadow_dropped = '0;
   logic        shadow_enable = 1'b0;

   // results still owed by the block, oldest first
   rx_result_type owed_results [$];

   can_rx_frame_queue #(
      .QUEUE_DEPTH (DEPTH)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_id_word          (req_id_word),
      .req_length_time_word (req_length_time_word),
      .req_data_low_word    (req_data_low_word),
      .req_data_high_word   (req_data_high_word),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_frame_id         (rsp_frame_id),
      .rsp_frame_extended   (rsp_frame_extended),
      .rsp_frame_remote     (rsp_frame_remote),
      .rsp_frame_length     (rsp_frame_length),
      .rsp_frame_timestamp  (rsp_frame_timestamp),
      .rsp_frame_data_low   (rsp_frame_data_low),
      .rsp_frame_data_high  (rsp_frame_data_high),
      .rsp_fill_level       (rsp_fill_level),
      .rsp_overflow_count   (rsp_overflow_count),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // decode one request, update the shadow queue and return what the block owes
   function automatic rx_result_type queue_frame_step(input logic        kind,
                                                      input logic [31:0] id_word,
                                                      input logic [31:0] len_time_word,
                                                      input logic [31:0] lo_word,
                                                      input logic [31:0] hi_word);
      rx_result_type  r;
      held_frame_type f;
      r.status    = ST_OK;
      r.id        = '0;
      r.extended  = 1'b0;
      r.remote    = 1'b0;
      r.length    = '0;
      r.timestamp = '0;
      r.bytes_lo  = '0;
      r.bytes_hi  = '0;
      if (!shadow_enable) begin
         r.status = ST_OFF;
      end else if (kind == REQ_PUSH) begin
         if (shadow_held >= DEPTH) begin
            // ring full: frame lost, counter sticks at its ceiling
            r.status = ST_FULL;
            if (shadow_dropped != DROP_CEILING)
               shadow_dropped = shadow_dropped + 16'd1;
         end else begin
            f.extended  = id_word[2];
            f.remote    = id_word[1];
            f.id        = id_word[2] ? id_word[31:3] : {18'd0, id_word[31:21]};
            f.length    = (len_time_word[3:0] > LEN_CLAMP) ? LEN_CLAMP : len_time_word[3:0];
            f.timestamp = len_time_word[31:16];
            f.data      = {hi_word, lo_word};
            shadow_frames[shadow_wr] = f;
            shadow_wr   = (shadow_wr + 1) % DEPTH;
            shadow_held = shadow_held + 1;
         end
      end else if (shadow_held == 0) begin
         r.status = ST_EMPTY;
      end else begin
         f           = shadow_frames[shadow_rd];
         r.id        = f.id;
         r.extended  = f.extended;
         r.remote    = f.remote;
         r.length    = f.length;
         r.timestamp = f.timestamp;
         r.bytes_lo  = f.data[31:0];
         r.bytes_hi  = f.data[63:32];
         shadow_rd   = (shadow_rd + 1) % DEPTH;
         shadow_held = shadow_held - 1;
      end
      r.fill    = 5'(shadow_held);
      r.dropped = shadow_dropped;
      return r;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got)
         note_mismatch($sformatf("%s expected %h got %h", name, want, got));
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99, 0) < rsp_idle_pct);
      end
   end

   // every result beat is matched against the oldest owed result
   always @(posedge clock) begin : check_results
      rx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing owed, status %0d", rsp_status));
         end else begin
            want = owed_results.pop_front();
            compare_field("status",    32'(want.status),    32'(rsp_status));
            compare_field("frame_id",  32'(want.id),        32'(rsp_frame_id));
            compare_field("extended",  32'(want.extended),  32'(rsp_frame_extended));
            compare_field("remote",    32'(want.remote),    32'(rsp_frame_remote));
            compare_field("length",    32'(want.length),    32'(rsp_frame_length));
            compare_field("timestamp", 32'(want.timestamp), 32'(rsp_frame_timestamp));
            compare_field("bytes 0-3", want.bytes_lo,       rsp_frame_data_low);
            compare_field("bytes 4-7", want.bytes_hi,       rsp_frame_data_high);
            compare_field("fill",      32'(want.fill),      32'(rsp_fill_level));
            compare_field("overflow",  32'(want.dropped),   32'(rsp_overflow_count));
         end
      end
   end

   // one request beat: random idle first, then hold until accepted
   task automatic send_item(input logic kind, input logic [31:0] id_word,
                            input logic [31:0] len_time_word,
                            input logic [31:0] lo_word, input logic [31:0] hi_word);
      @(negedge clock);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid            = 1'b1;
      req_type             = kind;
      req_id_word          = id_word;
      req_length_time_word = len_time_word;
      req_data_low_word    = lo_word;
      req_data_high_word   = hi_word;
      do @(posedge clock); while (req_stall);
      owed_results.push_back(queue_frame_step(kind, id_word, len_time_word,
                                              lo_word, hi_word));
   endtask

   task automatic pop_frame();
      send_item(REQ_POP, $urandom, $urandom, $urandom, $urandom);
   endtask

   // random push or pop with random raw words
   task automatic send_random(input int push_pct);
      logic kind;
      kind = ($urandom_range(99, 0) < push_pct) ? REQ_PUSH : REQ_POP;
      send_item(kind, $urandom, $urandom, $urandom, $urandom);
   endtask

   // sender goes quiet until every owed result is back, then waits out the settle period
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (owed_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write the enable register on an idle block, then read it back
   task automatic set_enable(input logic [31:0] value);
      wait_for_results();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = ADDR_ENABLE;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      shadow_enable = value[0];
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      compare_field("enable readback", {31'd0, value[0]}, prdata);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // disabled after reset: everything refused, upper data bits of the write ignored
   task automatic test_disabled();
      send_item(REQ_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(REQ_POP, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(REQ_PUSH, 32'h0, 32'h0, 32'h0, 32'h0);
      set_enable(32'hFFFF_FFFE);
      send_item(REQ_PUSH, $urandom, $urandom, $urandom, $urandom);
      pop_frame();
   endtask

   // decode corners: id formats, remote flag, length clamp, field extremes
   task automatic test_decode_corners();
      set_enable(32'd1);
      pop_frame();                                   // empty queue
      // standard id all ones, length 0, timestamp max
      send_item(REQ_PUSH, 32'hFFFF_FFF9, 32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      // extended remote, id all ones, length 8
      send_item(REQ_PUSH, 32'hFFFF_FFFE, 32'h0000_FFF8, 32'hFFFF_FFFF, 32'h0000_0000);
      // extended id zero, length code 9 clamps
      send_item(REQ_PUSH, 32'h0000_0004, 32'h1234_0009, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
      // standard remote, length code 15 clamps
      send_item(REQ_PUSH, 32'h0020_0002, 32'h0000_000F, 32'h1357_9BDF, 32'h2468_ACE0);
      send_item(REQ_PUSH, 32'h0000_0000, 32'h0001_0007, 32'h0000_0000, 32'h0000_0000);
      repeat (6) pop_frame();                        // last one finds it empty
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      set_enable(32'd1);
      hold_left = 120;
      repeat (40) send_random(60);
      // then the sender pauses until everything is back
      wait_for_results();
      repeat (20) send_random(50);
   endtask

   // phases of random traffic with varying mix, enable and idling
   task automatic test_random_traffic();
      int push_pct;
      for (int phase = 0; phase < 12; phase++) begin
         set_enable((phase % 5 == 4) ? 32'd0 : 32'd1);
         unique case (phase)
            1: push_pct = 85;                         // drive into full
            2: push_pct = 15;                         // drain into empty
            default: push_pct = $urandom_range(85, 15);
         endcase
         // one phase with no idling on either side
         req_idle_pct = (phase == 6) ? 0 : 20;
         rsp_idle_pct = (phase == 6) ? 0 : 20;
         repeat (85) send_random(push_pct);
      end
      req_idle_pct = 20;
      rsp_idle_pct = 20;
   endtask

   // fill the ring, then keep pushing so frames are dropped and counted
   task automatic test_overflow();
      set_enable(32'd1);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (shadow_held < DEPTH)
         send_item(REQ_PUSH, $urandom, $urandom, $urandom, $urandom);
      repeat (40) send_item(REQ_PUSH, $urandom, $urandom, $urandom, $urandom);
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      repeat (DEPTH + 1) pop_frame();
      set_enable(32'd0);
   endtask

   // main sequence
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_disabled();
      test_decode_corners();
      test_backpressure();
      test_random_traffic();
      test_overflow();
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
hdl/can_rxq_pkg.sv
hdl/can_rx_frame_queue.sv
test/testbench.sv
